### src/dwdm_pkg.sv
// Package with the widths, reset values and codes of the DRAM write drain mode controller.
package dwdm_pkg;

    localparam int CHANNELS    = 4;
    localparam int CHAN_W      = 2;
    localparam int QLEN_W      = 7;
    localparam int DELAY_W     = 8;
    localparam int DENSITY_W   = 16;
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [QLEN_W-1:0]    HIGH_WM_RESET   = 7'd62;
    localparam logic [QLEN_W-1:0]    LOW_WM_RESET    = 7'd36;
    localparam logic [DELAY_W-1:0]   DELAY_MAX_RESET = 8'd2;
    localparam logic [DENSITY_W-1:0] DENSITY_RESET   = 16'd20;
    localparam logic [DENSITY_W-1:0] DENSITY_FULL    = 16'hFFFF;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_HIGH_WATERMARK    = 2'd0,
        REG_LOW_WATERMARK     = 2'd1,
        REG_DRAIN_DELAY_MAX   = 2'd2,
        REG_DENSITY_THRESHOLD = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ISSUE_NONE  = 2'd0,
        ISSUE_READ  = 2'd1,
        ISSUE_WRITE = 2'd2,
        ISSUE_BAD   = 2'd3
    } issue_t;

    typedef struct packed {
        logic [CHAN_W-1:0] chan;
        logic [QLEN_W-1:0] write_queue_len;
        logic [QLEN_W-1:0] read_queue_len;
        logic              write_hit_ready;
        logic              read_hit_ready;
        logic              period_boundary;
    } item_t;

endpackage

### src/dram_write_drain_mode_controller.sv
// Top level of the DRAM write drain mode controller with its per-channel state.
// One transaction per clock: an item is captured in an input register, and then a
// single pass of compare and select logic reads the state of its channel, updates it
// and loads the result register, which drives the item's result onto the output. A
// new item may follow in every cycle, also for the same channel, since the state is
// written at the same edge that loads the result. Flow stops only while the result
// register holds an untaken result.
// The configuration channel is always ready; write it only while the block is idle.
module dram_write_drain_mode_controller (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // Fields from bit 0: chan[1:0], write_queue_len[8:2], read_queue_len[15:9],
    // write_hit_ready[16], read_hit_ready[17], period_boundary[18], zeros above.
    input  logic [dwdm_pkg::IN_DATA_W-1:0]       s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // Fields from bit 0: write_mode[0], column_issue[2:1], zeros above.
    output logic [dwdm_pkg::OUT_DATA_W-1:0]      m_tdata,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [dwdm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [dwdm_pkg::CFG_DATA_W-1:0]      cfg_data
);

    logic [dwdm_pkg::QLEN_W-1:0]    high_wm_reg;
    logic [dwdm_pkg::QLEN_W-1:0]    low_wm_reg;
    logic [dwdm_pkg::DELAY_W-1:0]   delay_max_reg;
    logic [dwdm_pkg::DENSITY_W-1:0] threshold_reg;

    logic                           drain_mode_reg [dwdm_pkg::CHANNELS];
    logic [dwdm_pkg::DELAY_W-1:0]   delay_count_reg [dwdm_pkg::CHANNELS];
    logic [dwdm_pkg::DENSITY_W-1:0] density_count_reg [dwdm_pkg::CHANNELS];
    logic                           delayed_on_reg [dwdm_pkg::CHANNELS];

    logic                  in_valid_reg;
    dwdm_pkg::item_t       item_reg;
    logic                  out_valid_reg;
    logic                  write_mode_reg;
    dwdm_pkg::issue_t      issue_reg;

    logic                           advance;
    logic                           update;
    logic                           delayed_on;
    logic [dwdm_pkg::DENSITY_W-1:0] density_base;
    logic [dwdm_pkg::DELAY_W-1:0]   delay_next;
    logic [dwdm_pkg::DENSITY_W-1:0] density_next;
    logic                           mode_next;
    dwdm_pkg::issue_t               issue_next;

    assign advance   = !out_valid_reg || m_tready;
    assign update    = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {5'd0, issue_reg, write_mode_reg};

    always_comb begin
        delayed_on   = delayed_on_reg[item_reg.chan];
        density_base = density_count_reg[item_reg.chan];
        if (item_reg.period_boundary) begin
            delayed_on   = !(density_count_reg[item_reg.chan] > threshold_reg);
            density_base = '0;
        end

        delay_next = delay_count_reg[item_reg.chan];
        mode_next  = drain_mode_reg[item_reg.chan];
        if (item_reg.write_queue_len < low_wm_reg) begin
            mode_next = 1'b0;
        end

        if (item_reg.write_queue_len > high_wm_reg) begin
            mode_next = 1'b1;
        end else if (item_reg.write_queue_len == '0) begin
            mode_next = 1'b0;
        end else if (item_reg.read_queue_len == '0) begin
            if (delayed_on) begin
                if (delay_count_reg[item_reg.chan] < delay_max_reg) begin
                    mode_next  = 1'b0;
                    delay_next = delay_count_reg[item_reg.chan] + 8'd1;
                end else begin
                    mode_next = 1'b1;
                    if (item_reg.write_queue_len < low_wm_reg) begin
                        delay_next = '0;
                    end
                end
            end else begin
                mode_next = 1'b1;
            end
        end else begin
            delay_next = '0;
            if (mode_next) begin
                mode_next = item_reg.write_hit_ready || !item_reg.read_hit_ready;
            end else begin
                mode_next = !item_reg.read_hit_ready && item_reg.write_hit_ready;
            end
        end

        issue_next = dwdm_pkg::ISSUE_NONE;
        if (mode_next && item_reg.write_hit_ready) begin
            issue_next = dwdm_pkg::ISSUE_WRITE;
        end else if (!mode_next && item_reg.read_hit_ready) begin
            issue_next = dwdm_pkg::ISSUE_READ;
        end

        density_next = density_base;
        if (issue_next != dwdm_pkg::ISSUE_NONE && density_base != dwdm_pkg::DENSITY_FULL) begin
            density_next = density_base + 16'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_wm_reg   <= dwdm_pkg::HIGH_WM_RESET;
            low_wm_reg    <= dwdm_pkg::LOW_WM_RESET;
            delay_max_reg <= dwdm_pkg::DELAY_MAX_RESET;
            threshold_reg <= dwdm_pkg::DENSITY_RESET;
        end else if (cfg_valid) begin
            case (dwdm_pkg::cfg_reg_t'(cfg_index))
                dwdm_pkg::REG_HIGH_WATERMARK:    high_wm_reg   <= cfg_data[dwdm_pkg::QLEN_W-1:0];
                dwdm_pkg::REG_LOW_WATERMARK:     low_wm_reg    <= cfg_data[dwdm_pkg::QLEN_W-1:0];
                dwdm_pkg::REG_DRAIN_DELAY_MAX:   delay_max_reg <= cfg_data[dwdm_pkg::DELAY_W-1:0];
                dwdm_pkg::REG_DENSITY_THRESHOLD: threshold_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < dwdm_pkg::CHANNELS; i++) begin
                drain_mode_reg[i]    <= 1'b0;
                delay_count_reg[i]   <= '0;
                density_count_reg[i] <= '0;
                delayed_on_reg[i]    <= 1'b0;
            end
        end else if (update) begin
            drain_mode_reg[item_reg.chan]    <= mode_next;
            delay_count_reg[item_reg.chan]   <= delay_next;
            density_count_reg[item_reg.chan] <= density_next;
            delayed_on_reg[item_reg.chan]    <= delayed_on;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= dwdm_pkg::item_t'({s_tdata[1:0], s_tdata[8:2], s_tdata[15:9],
                                           s_tdata[16], s_tdata[17], s_tdata[18]});
        end
        if (update) begin
            write_mode_reg <= mode_next;
            issue_reg      <= issue_next;
        end
    end

    a_write_issue_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && issue_reg == dwdm_pkg::ISSUE_WRITE) |-> write_mode_reg)
        else $error("Write column issue reported outside write drain mode.");

    a_read_issue_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && issue_reg == dwdm_pkg::ISSUE_READ) |-> !write_mode_reg)
        else $error("Read column issue reported during write drain mode.");

    a_issue_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (issue_reg != dwdm_pkg::ISSUE_BAD))
        else $error("Undefined column issue code on the result channel.");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        update |=> m_tvalid)
        else $error("A processed transaction left no result.");

endmodule
